>>> hdl/ordered_timer_queue_core_assert.svh
// Assertion macros shared by the timer queue modules.
// Each expects clk and rst in scope; checks are off while rst is high.
`ifndef ORDERED_TIMER_QUEUE_CORE_ASSERT_SVH
`define ORDERED_TIMER_QUEUE_CORE_ASSERT_SVH

// When ante holds, cons must hold in the same cycle.
`define OTQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// When ante holds, cons must hold in the next cycle.
`define OTQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/otq_pkg.sv
package otq_pkg;

  localparam int TIMER_COUNT = 16;
  localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int CNT_W = $clog2(TIMER_COUNT + 1);
  localparam int TICK_W = 32;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_START  = 2'd1,
    ACT_STOP   = 2'd2,
    ACT_RELOAD = 2'd3
  } action_t;

  typedef struct packed {
    logic latch;
    logic tick_inc;
    logic take;
    logic emit;
    logic emit_last;
    logic drop_front;
    logic pos_inc;
    logic unlink;
    logic set_dl;
    logic insert;
  } otq_cmd_t;

  typedef struct packed {
    action_t act;
    logic    in_ok;
    logic    due;
    logic    pend_valid;
    logic    out_busy;
    logic    is_active;
    logic    match;
    logic    pos_end;
    logic    ins_here;
  } otq_sts_t;

endpackage

>>> hdl/ordered_timer_queue_core.sv
// Ordered one-shot timer queue.
// Input channel s_*: one item per command. s_tuser carries the action (tick, start,
// stop, set reload); s_tdata carries the timer index and the reload tick count.
// Output channel m_*: one item per expired timer, emitted only on a tick, in
// deadline order; m_tlast marks the final expiry of that tick.
// Items are taken one at a time; s_tready is high only while the block is idle.
// Set-reload is written as the command is accepted. Stop and start walk the
// sorted list one entry per cycle: stop to unlink the timer if it is running,
// start first to unlink it if it is running, then to find the insertion slot.
// A tick first advances the tick counter, then pops the due timers in deadline
// order; each popped timer is held back in a pending register so its last flag
// is known.
// Results go through an output register; when m_tready is low the expiry walk
// holds until the register frees, and no result is lost. The next command is
// accepted while the final result of a tick still waits.
// Synchronous reset clears the tick counter, all reload values and the running
// set; no clearing pass is needed.
module ordered_timer_queue_core
  import otq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [3:0] timer_index, [35:4] reload_ticks, [39:36] zero
  input  logic [1:0]  s_tuser,   // [1:0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [3:0] expired_timer, [35:4] now_ticks, [39:36] zero
  output logic        m_tlast    // last_one
);

  otq_cmd_t    cmd;
  otq_sts_t    sts;
  logic [3:0]  out_timer;
  logic [31:0] out_now;

  otq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_action(action_t'(s_tuser)),
    .sts      (sts),
    .cmd      (cmd)
  );

  otq_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .in_action(s_tuser),
    .in_index (s_tdata[3:0]),
    .in_reload(s_tdata[35:4]),
    .out_ready(m_tready),
    .out_valid(m_tvalid),
    .out_timer(out_timer),
    .out_now  (out_now),
    .out_last (m_tlast)
  );

  assign m_tdata = {4'd0, out_now, out_timer};

endmodule

>>> hdl/otq_datapath.sv
module otq_datapath
  import otq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  otq_cmd_t    cmd,
  output otq_sts_t    sts,
  input  logic [1:0]  in_action,
  input  logic [3:0]  in_index,
  input  logic [31:0] in_reload,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [3:0]  out_timer,
  output logic [31:0] out_now,
  output logic        out_last
);

  action_t            act_q;
  logic [IDX_W-1:0]   idx_q;
  logic [TICK_W-1:0]  tick_count;
  logic [TICK_W-1:0]  reload_table [TIMER_COUNT];
  logic [TICK_W-1:0]  deadline_table [TIMER_COUNT];
  logic [TIMER_COUNT-1:0] active;
  logic [IDX_W-1:0]   order_list [TIMER_COUNT];
  logic [CNT_W-1:0]   active_count;
  logic [CNT_W-1:0]   pos;
  logic [TICK_W-1:0]  dl;
  logic [IDX_W-1:0]   pend_idx;
  logic               pend_valid;

  logic [IDX_W-1:0]   in_idx;
  logic [IDX_W-1:0]   cur;
  logic [TICK_W-1:0]  cur_dl;
  logic [TICK_W-1:0]  diff_due;
  logic [TICK_W-1:0]  diff_ins;
  logic [TICK_W-1:0]  new_dl;

  assign in_idx   = IDX_W'(in_index);
  assign cur      = order_list[pos[IDX_W-1:0]];
  assign cur_dl   = deadline_table[cur];
  assign diff_due = tick_count - cur_dl;
  assign diff_ins = cur_dl - dl;
  assign new_dl   = tick_count + reload_table[idx_q];

  always_comb begin
    sts.act        = act_q;
    sts.in_ok      = ({28'd0, in_index} < 32'(TIMER_COUNT));
    sts.due        = (pos < active_count) && !diff_due[TICK_W-1];
    sts.pend_valid = pend_valid;
    sts.out_busy   = out_valid && !out_ready;
    sts.is_active  = active[idx_q];
    sts.match      = (cur == idx_q);
    sts.pos_end    = (pos == active_count);
    sts.ins_here   = (diff_ins != '0) && !diff_ins[TICK_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      active <= '0;
      active_count <= '0;
      pos <= '0;
      pend_valid <= 1'b0;
      out_valid <= 1'b0;
      act_q <= ACT_TICK;
      for (int i = 0; i < TIMER_COUNT; i++) begin
        reload_table[i] <= '0;
      end
    end else begin
      if (cmd.latch) begin
        act_q <= action_t'(in_action);
        idx_q <= in_idx;
        if (action_t'(in_action) == ACT_RELOAD && sts.in_ok) begin
          reload_table[in_idx] <= in_reload;
        end
      end
      if (cmd.tick_inc) begin
        tick_count <= tick_count + 1'b1;
      end
      if (cmd.set_dl) begin
        deadline_table[idx_q] <= new_dl;
        dl <= new_dl;
      end

      if (cmd.latch || cmd.drop_front || cmd.set_dl) begin
        pos <= '0;
      end else if (cmd.take || cmd.pos_inc) begin
        pos <= pos + 1'b1;
      end

      // hold the popped timer back in a pending register so its last flag is known
      if (cmd.take) begin
        active[cur] <= 1'b0;
        pend_idx <= cur;
        pend_valid <= 1'b1;
      end else if (cmd.emit) begin
        pend_valid <= 1'b0;
      end

      if (cmd.unlink) begin
        for (int i = 0; i < TIMER_COUNT - 1; i++) begin
          if (CNT_W'(i) >= pos) begin
            order_list[i] <= order_list[i + 1];
          end
        end
        active_count <= active_count - 1'b1;
        active[idx_q] <= 1'b0;
      end else if (cmd.insert) begin
        for (int i = 0; i < TIMER_COUNT; i++) begin
          if (CNT_W'(i) == pos) begin
            order_list[i] <= idx_q;
          end else if (i > 0 && CNT_W'(i) > pos) begin
            order_list[i] <= order_list[i - 1];
          end
        end
        active_count <= active_count + 1'b1;
        active[idx_q] <= 1'b1;
      end else if (cmd.drop_front) begin
        // advance the list past every timer popped on this tick
        for (int i = 0; i < TIMER_COUNT; i++) begin
          if ((CNT_W + 1)'(i) + (CNT_W + 1)'(pos) < (CNT_W + 1)'(TIMER_COUNT)) begin
            order_list[i] <= order_list[IDX_W'(i + int'(pos))];
          end
        end
        active_count <= active_count - pos;
      end

      if (cmd.emit) begin
        out_valid <= 1'b1;
        out_timer <= 4'(pend_idx);
        out_now <= tick_count;
        out_last <= cmd.emit_last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  function automatic int pos_taken();
    pos_taken = (act_q == ACT_TICK) ? int'(pos) : 0;
  endfunction

`include "ordered_timer_queue_core_assert.svh"

  `OTQ_ASSERT_IMPL(a_count_bound, 1'b1, active_count <= CNT_W'(TIMER_COUNT), "count overflow")
  `OTQ_ASSERT_IMPL(a_flags_match_count, 1'b1,
    $countones(active) == int'(active_count) - int'(pos_taken()),
    "active flags disagree with count")
  `OTQ_ASSERT_IMPL(a_emit_pending, cmd.emit, pend_valid, "emit without pending timer")
  `OTQ_ASSERT_IMPL(a_insert_inactive, cmd.insert, !active[idx_q], "insert of listed timer")

endmodule

>>> hdl/otq_ctrl.sv
module otq_ctrl
  import otq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  action_t  in_action,
  input  otq_sts_t sts,
  output otq_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_TICK = 6'b000010,
    S_DUE  = 6'b000100,
    S_UNL  = 6'b001000,
    S_DL   = 6'b010000,
    S_LINK = 6'b100000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          if (in_action == ACT_TICK) begin
            state_next = S_TICK;
          end else if (sts.in_ok && (in_action == ACT_START || in_action == ACT_STOP)) begin
            state_next = S_UNL;
          end
        end
      end
      S_TICK: begin
        cmd.tick_inc = 1'b1;
        state_next = S_DUE;
      end
      S_DUE: begin
        if (sts.due) begin
          if (!(sts.pend_valid && sts.out_busy)) begin
            cmd.emit = sts.pend_valid;
            cmd.take = 1'b1;
          end
        end else if (!sts.pend_valid) begin
          cmd.drop_front = 1'b1;
          state_next = S_IDLE;
        end else if (!sts.out_busy) begin
          cmd.emit = 1'b1;
          cmd.emit_last = 1'b1;
          cmd.drop_front = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_UNL: begin
        if (!sts.is_active || sts.match) begin
          cmd.unlink = sts.is_active;
          state_next = (sts.act == ACT_START) ? S_DL : S_IDLE;
        end else begin
          cmd.pos_inc = 1'b1;
        end
      end
      S_DL: begin
        cmd.set_dl = 1'b1;
        state_next = S_LINK;
      end
      S_LINK: begin
        if (sts.pos_end || sts.ins_here) begin
          cmd.insert = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.pos_inc = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`include "ordered_timer_queue_core_assert.svh"

  `OTQ_ASSERT_NEXT(a_tick_then_due, state == S_TICK, state == S_DUE, "tick did not check expiry")
  `OTQ_ASSERT_IMPL(a_one_list_op, 1'b1,
    $countones({cmd.unlink, cmd.insert, cmd.drop_front}) <= 1, "list ops collide")
  `OTQ_ASSERT_NEXT(a_dl_then_link, state == S_DL, state == S_LINK, "deadline not followed by link")

endmodule
